### rtl/u16550_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16550_pkg
// Shared types, register offsets, bit masks and stream widths for the
// 16550-style UART register model.
// ----------------------------------------------------------------------------
package u16550_pkg;

   // Item kinds on the request channel
   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_LINE  = 2'd2
   } kind_type;

   // Register offsets
   localparam logic [2:0] REG_RBR = 3'd0;   // RBR / THR / DLL
   localparam logic [2:0] REG_IER = 3'd1;   // IER / DLM
   localparam logic [2:0] REG_IIR = 3'd2;   // IIR / FCR
   localparam logic [2:0] REG_LCR = 3'd3;
   localparam logic [2:0] REG_MCR = 3'd4;
   localparam logic [2:0] REG_LSR = 3'd5;
   localparam logic [2:0] REG_MSR = 3'd6;
   localparam logic [2:0] REG_SCR = 3'd7;

   // Bit positions and fixed codes
   localparam int LCR_DLAB_BIT  = 7;
   localparam int MCR_OUT2_BIT  = 3;
   localparam int MCR_LOOP_BIT  = 4;
   localparam int FCR_EN_BIT    = 0;
   localparam int FCR_FLUSH_BIT = 1;

   localparam logic [7:0] IIR_NONE     = 8'h01;
   localparam logic [7:0] IIR_RX_DATA  = 8'h04;
   localparam logic [7:0] IIR_FIFO_ON  = 8'hC0;
   localparam logic [7:0] LSR_TX_EMPTY = 8'h60;

   // Stream widths
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   // Receive trigger level in bytes
   function automatic logic [3:0] trig_level(input logic fifo_on, input logic [1:0] code);
      logic [3:0] lvl;
      begin
         lvl = 4'd1;
         if (fifo_on) begin
            case (code)
               2'd0:    lvl = 4'd1;
               2'd1:    lvl = 4'd4;
               2'd2:    lvl = 4'd8;
               default: lvl = 4'd14;
            endcase
         end
         return lvl;
      end
   endfunction

endpackage

### rtl/uart_16550_register_model_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_16550_register_model_unit
// Register file and receive FIFO of a 16550-style UART, driven by a stream
// of bus reads, bus writes and bytes from the line.
// ----------------------------------------------------------------------------
// Every request item returns exactly one response item. The block takes one
// item per clock: an item is registered on entry, does its register and FIFO
// update on its way into the response register, and shows on the response
// port from that register. Throughput is limited only by the response side;
// while a response waits, the input register takes one more item and then
// holds the request side. The receive FIFO is a FIFO_DEPTH-byte memory with
// a registered read port that always holds the entry at the head, with a
// bypass for a byte written to the head slot in the same cycle.
module uart_16550_register_model_unit #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [2:0] reg_offset, [10:3] write_data, [18:11] line_byte,
   // [22:19] modem_inputs, [23] zero
   input  logic [u16550_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] kind
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] read_data, [15:8] tx_byte, [16] irq, [23:17] zero
   output logic [u16550_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [0] tx_valid
   output logic                               rsp_tuser
);
   import u16550_pkg::*;

   localparam int ADDR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_W  = $clog2(2 * FIFO_DEPTH);

   // Input register
   logic             s1_valid_ff, s1_valid_in;
   kind_type         s1_kind_ff;
   logic [2:0]       s1_off_ff;
   logic [7:0]       s1_wdata_ff;
   logic [7:0]       s1_lbyte_ff;
   logic [3:0]       s1_modem_ff;

   // Response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_rdata_ff, rsp_rdata_in;
   logic             rsp_txv_ff, rsp_txv_in;
   logic [7:0]       rsp_txb_ff, rsp_txb_in;
   logic             rsp_irq_ff, rsp_irq_in;

   // UART state
   logic [ADDR_W-1:0] rx_head_ff, rx_head_in;
   logic [CNT_W-1:0]  rx_count_ff, rx_count_in;
   logic [7:0]        div_lo_ff, div_lo_in;
   logic [7:0]        div_hi_ff, div_hi_in;
   logic [3:0]        ier_ff, ier_in;
   logic [7:0]        lcr_ff, lcr_in;
   logic [4:0]        mcr_ff, mcr_in;
   logic [7:0]        scr_ff, scr_in;
   logic              fifo_on_ff, fifo_on_in;
   logic [1:0]        trig_ff, trig_in;
   logic              overrun_ff, overrun_in;

   // Receive memory and head read port
   logic [7:0]        rx_mem [FIFO_DEPTH];
   logic [7:0]        head_rd_ff;
   logic              byp_ff;
   logic [7:0]        byp_data_ff;
   logic [7:0]        head_byte;

   logic              adv;
   logic              work;
   logic              dlab;
   logic              loop_on;
   logic              rx_cond;
   logic              push_req;
   logic [7:0]        push_byte;
   logic              pop_req;
   logic              flush;
   logic              wr_en;
   logic [SUM_W-1:0]  wr_sum;
   logic [ADDR_W-1:0] wr_addr;
   logic [CNT_W-1:0]  cap;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign work       = s1_valid_ff && adv;
   assign req_tready = !s1_valid_ff || adv;

   assign s1_valid_in  = (req_tvalid && req_tready) ? 1'b1 : (adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = work ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   assign dlab      = lcr_ff[LCR_DLAB_BIT];
   assign loop_on   = mcr_ff[MCR_LOOP_BIT];
   assign head_byte = byp_ff ? byp_data_ff : head_rd_ff;
   assign rx_cond   = ier_ff[0] &&
                      (rx_count_ff >= CNT_W'(trig_level(fifo_on_ff, trig_ff)));
   assign cap       = fifo_on_ff ? CNT_W'(FIFO_DEPTH) : CNT_W'(1);

   // Tail slot of the circular buffer
   always_comb begin
      wr_sum = SUM_W'(rx_head_ff) + SUM_W'(rx_count_ff);
      if (wr_sum >= SUM_W'(FIFO_DEPTH)) begin
         wr_sum = wr_sum - SUM_W'(FIFO_DEPTH);
      end
      wr_addr = wr_sum[ADDR_W-1:0];
   end

   always_comb begin
      rx_head_in   = rx_head_ff;
      rx_count_in  = rx_count_ff;
      div_lo_in    = div_lo_ff;
      div_hi_in    = div_hi_ff;
      ier_in       = ier_ff;
      lcr_in       = lcr_ff;
      mcr_in       = mcr_ff;
      scr_in       = scr_ff;
      fifo_on_in   = fifo_on_ff;
      trig_in      = trig_ff;
      overrun_in   = overrun_ff;
      rsp_rdata_in = rsp_rdata_ff;
      rsp_txv_in   = rsp_txv_ff;
      rsp_txb_in   = rsp_txb_ff;
      rsp_irq_in   = rsp_irq_ff;
      push_req     = 1'b0;
      push_byte    = s1_wdata_ff;
      pop_req      = 1'b0;
      flush        = 1'b0;
      wr_en        = 1'b0;

      if (work) begin
         rsp_rdata_in = 8'h00;
         rsp_txv_in   = 1'b0;
         rsp_txb_in   = 8'h00;
         case (s1_kind_ff)
            KIND_READ: begin
               case (s1_off_ff)
                  REG_RBR: begin
                     if (dlab) begin
                        rsp_rdata_in = div_lo_ff;
                     end else if (rx_count_ff != '0) begin
                        rsp_rdata_in = head_byte;
                        pop_req      = 1'b1;
                     end
                  end
                  REG_IER: rsp_rdata_in = dlab ? div_hi_ff : {4'h0, ier_ff};
                  REG_IIR: rsp_rdata_in = (rx_cond ? IIR_RX_DATA : IIR_NONE) |
                                          (fifo_on_ff ? IIR_FIFO_ON : 8'h00);
                  REG_LCR: rsp_rdata_in = lcr_ff;
                  REG_MCR: rsp_rdata_in = {3'b000, mcr_ff};
                  REG_LSR: begin
                     rsp_rdata_in = LSR_TX_EMPTY |
                                    {6'b0, overrun_ff, rx_count_ff != '0};
                     overrun_in   = 1'b0;
                  end
                  REG_MSR: begin
                     // loopback: DCD=OUT2, RI=OUT1, DSR=DTR, CTS=RTS
                     rsp_rdata_in = loop_on ?
                                    {mcr_ff[3], mcr_ff[2], mcr_ff[0], mcr_ff[1], 4'h0} :
                                    {s1_modem_ff, 4'h0};
                  end
                  default: rsp_rdata_in = scr_ff;
               endcase
            end
            KIND_WRITE: begin
               case (s1_off_ff)
                  REG_RBR: begin
                     if (dlab) begin
                        div_lo_in = s1_wdata_ff;
                     end else if (loop_on) begin
                        push_req = 1'b1;
                     end else begin
                        rsp_txv_in = 1'b1;
                        rsp_txb_in = s1_wdata_ff;
                     end
                  end
                  REG_IER: begin
                     if (dlab) begin
                        div_hi_in = s1_wdata_ff;
                     end else begin
                        ier_in = s1_wdata_ff[3:0];
                     end
                  end
                  REG_IIR: begin
                     flush      = s1_wdata_ff[FCR_FLUSH_BIT] ||
                                  (s1_wdata_ff[FCR_EN_BIT] != fifo_on_ff);
                     fifo_on_in = s1_wdata_ff[FCR_EN_BIT];
                     trig_in    = s1_wdata_ff[7:6];
                  end
                  REG_LCR: lcr_in = s1_wdata_ff;
                  REG_MCR: mcr_in = s1_wdata_ff[4:0];
                  REG_SCR: scr_in = s1_wdata_ff;
                  default: ;
               endcase
            end
            KIND_LINE: begin
               if (!loop_on) begin
                  push_req  = 1'b1;
                  push_byte = s1_lbyte_ff;
               end
            end
            default: ;
         endcase

         if (push_req) begin
            if (rx_count_ff >= cap) begin
               overrun_in = 1'b1;
            end else begin
               wr_en       = 1'b1;
               rx_count_in = rx_count_ff + CNT_W'(1);
            end
         end
         if (pop_req) begin
            rx_head_in  = (rx_head_ff == ADDR_W'(FIFO_DEPTH - 1)) ? '0 :
                          rx_head_ff + ADDR_W'(1);
            rx_count_in = rx_count_ff - CNT_W'(1);
         end
         if (flush) begin
            rx_head_in  = '0;
            rx_count_in = '0;
         end

         // interrupt reflects the state after this item
         rsp_irq_in = ier_in[0] && mcr_in[MCR_OUT2_BIT] &&
                      (rx_count_in >= CNT_W'(trig_level(fifo_on_in, trig_in)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rx_head_ff   <= '0;
         rx_count_ff  <= '0;
         div_lo_ff    <= '0;
         div_hi_ff    <= '0;
         ier_ff       <= '0;
         lcr_ff       <= '0;
         mcr_ff       <= '0;
         scr_ff       <= '0;
         fifo_on_ff   <= 1'b0;
         trig_ff      <= '0;
         overrun_ff   <= 1'b0;
         byp_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rx_head_ff   <= rx_head_in;
         rx_count_ff  <= rx_count_in;
         div_lo_ff    <= div_lo_in;
         div_hi_ff    <= div_hi_in;
         ier_ff       <= ier_in;
         lcr_ff       <= lcr_in;
         mcr_ff       <= mcr_in;
         scr_ff       <= scr_in;
         fifo_on_ff   <= fifo_on_in;
         trig_ff      <= trig_in;
         overrun_ff   <= overrun_in;
         // a byte landing in the next head slot is not yet visible on the read port
         byp_ff       <= wr_en && (wr_addr == rx_head_in);
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_kind_ff  <= kind_type'(req_tuser);
         s1_off_ff   <= req_tdata[2:0];
         s1_wdata_ff <= req_tdata[10:3];
         s1_lbyte_ff <= req_tdata[18:11];
         s1_modem_ff <= req_tdata[22:19];
      end
      rsp_rdata_ff <= rsp_rdata_in;
      rsp_txv_ff   <= rsp_txv_in;
      rsp_txb_ff   <= rsp_txb_in;
      rsp_irq_ff   <= rsp_irq_in;
      byp_data_ff  <= push_byte;
   end

   // Receive memory: one write port, head read port registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rx_mem[wr_addr] <= push_byte;
      end
      head_rd_ff <= rx_mem[rx_head_in];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_irq_ff, rsp_txb_ff, rsp_rdata_ff};
   assign rsp_tuser  = rsp_txv_ff;

endmodule

### rtl/u16550_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16550_checker
// Port-level checks for the UART register model: response handshake and
// consistency of the transmit and read fields.
// ----------------------------------------------------------------------------
module u16550_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [u16550_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                               rsp_tuser
);
   import u16550_pkg::*;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // a transmitted byte never comes with read data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[7:0] == 8'h00)
      else $error("tx item carries read data");

   // tx byte is zero when nothing is sent
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[15:8] == 8'h00)
      else $error("tx byte without tx valid");

   // an item taken while the response port is idle and ready shows up as a response
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid && rsp_tready |=> ##1 rsp_tvalid)
      else $error("response missing");

endmodule

bind uart_16550_register_model_unit u16550_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
